// ----- rtl/core/mvdi_pkg.sv -----
// Package for the mesh vertex dedup indexer: item structs and result codes.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package mvdi_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned Words = 8;
	localparam int unsigned VtxW = WordW * Words;
	localparam int unsigned CountW = 13;

	localparam logic [1:0] KIND_FIRST = 2'd0;
	localparam logic [1:0] KIND_SAME = 2'd1;
	localparam logic [1:0] KIND_DUP_OLD = 2'd2;
	localparam logic [1:0] KIND_DUP_NEW = 2'd3;

	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_RANGE = 2'd1;
	localparam logic [1:0] FAULT_FULL = 2'd2;

	typedef struct packed {
		logic [11:0] pos_index;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
		logic        mesh_end;
	} corner_t;

	typedef struct packed {
		logic [12:0] vertex_index;
		logic [1:0]  corner_kind;
		logic [1:0]  fault;
		logic        last_corner;
	} result_t;
endpackage
`default_nettype wire

// ----- rtl/core/mvdi_store.sv -----
// Vertex store: one-port synchronous RAM holding whole vertices, with registered read data.
// Uses mvdi_pkg for the vertex width.
`timescale 1ns / 1ps
`default_nettype none
module mvdi_store #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input  wire                          clk,
	input  wire                          we,
	input  wire  [AW-1:0]                addr,
	input  wire  [mvdi_pkg::VtxW-1:0]    wdata,
	output logic [mvdi_pkg::VtxW-1:0]    rdata
);
	logic [mvdi_pkg::VtxW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/mesh_vertex_dedup_indexer.sv -----
// Mesh vertex dedup indexer top level: control sequencer, seen-flag RAM,
// first-vertex and duplicate RAMs (mvdi_store). Depends on mvdi_pkg.
//
// One corner item at a time, taken in the idle state. An out-of-range index goes
// from ST_SEEN straight to ST_OUT; a first use passes through ST_FIRST; a
// same-vertex hit is found in ST_DUPRD; a duplicate lookup alternates ST_DUPRD and
// ST_DUPCMP, one pair per stored duplicate compared and a last pair if none matches.
// After reset and after each mesh-end corner, a clearing pass walks the
// seen-flag RAM, one entry a cycle, over all MAX_POSITIONS entries, with no item taken.
// The result sits in an output register; the next item is taken while it waits,
// and the following result is held until the waiting one has been delivered.
`timescale 1ns / 1ps
`default_nettype none
module mesh_vertex_dedup_indexer #(
	parameter int unsigned MAX_POSITIONS = 4096,
	parameter int unsigned MAX_DUPLICATES = 1024
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire  [12:0]            cfg_wdata,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  mvdi_pkg::corner_t in_item,
	output logic                   out_valid,
	input  wire                    out_stall,
	output mvdi_pkg::result_t      out_item
);
	localparam int unsigned PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int unsigned DW = (MAX_DUPLICATES > 1) ? $clog2(MAX_DUPLICATES) : 1;
	localparam int unsigned DCW = $clog2(MAX_DUPLICATES + 1);
	localparam int unsigned LW = $clog2(MAX_POSITIONS + 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SEEN, ST_FIRST, ST_DUPRD, ST_DUPCMP, ST_OUT
	} state_t;

	state_t state_q;
	logic [12:0] pcount_q;
	mvdi_pkg::corner_t item_q;
	mvdi_pkg::result_t res_q;
	logic [mvdi_pkg::VtxW-1:0] vtx;
	logic [PW-1:0] clr_q;
	logic [DCW-1:0] dcount_q;
	logic [DCW-1:0] slot_q;
	logic seen_mem [MAX_POSITIONS];
	logic seen_rd;
	logic seen_we;
	logic seen_wd;
	logic [PW-1:0] seen_addr;
	logic [PW-1:0] pidx;
	logic fv_we;
	logic [mvdi_pkg::VtxW-1:0] fv_rd;
	logic dv_we;
	logic [DW-1:0] dv_addr;
	logic [mvdi_pkg::VtxW-1:0] dv_rd;
	logic [LW-1:0] limit;
	logic in_range;
	logic take;
	logic out_load;

	assign vtx = {item_q.pos_x, item_q.pos_y, item_q.pos_z, item_q.tex_u,
		item_q.tex_v, item_q.norm_x, item_q.norm_y, item_q.norm_z};
	assign pidx = PW'(item_q.pos_index);
	assign limit = ({19'd0, pcount_q} > 32'(MAX_POSITIONS)) ? LW'(MAX_POSITIONS)
		: LW'(pcount_q);
	assign in_range = (item_q.pos_index != 12'd0)
		&& ({20'd0, item_q.pos_index} < 32'(limit));
	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	always_comb begin
		seen_we = 1'b0;
		seen_wd = 1'b0;
		seen_addr = take ? PW'(in_item.pos_index) : pidx;
		if (state_q == ST_CLEAR) begin
			seen_we = 1'b1;
			seen_addr = clr_q;
		end else if (state_q == ST_FIRST) begin
			seen_we = 1'b1;
			seen_wd = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_addr] <= seen_wd;
		end
		seen_rd <= seen_mem[seen_addr];
	end

	assign fv_we = (state_q == ST_FIRST);
	assign dv_we = (state_q == ST_DUPCMP) && (slot_q == dcount_q)
		&& (dcount_q < DCW'(MAX_DUPLICATES));
	assign dv_addr = DW'(slot_q);

	mvdi_store #(.DEPTH(MAX_POSITIONS), .AW(PW)) u_first (
		.clk(clk), .we(fv_we), .addr(pidx), .wdata(vtx), .rdata(fv_rd)
	);

	mvdi_store #(.DEPTH(MAX_DUPLICATES), .AW(DW)) u_dup (
		.clk(clk), .we(dv_we), .addr(dv_addr), .wdata(vtx), .rdata(dv_rd)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pcount_q <= 13'd1;
			clr_q <= '0;
			dcount_q <= '0;
			slot_q <= '0;
			res_q <= '0;
			out_valid <= 1'b0;
			out_item <= '0;
		end else begin
			if (cfg_we) begin
				pcount_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid <= 1'b1;
				out_item <= res_q;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_POSITIONS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_SEEN;
					end
				end
				ST_SEEN: begin
					res_q.last_corner <= item_q.mesh_end;
					slot_q <= '0;
					if (!in_range) begin
						res_q.vertex_index <= '0;
						res_q.corner_kind <= mvdi_pkg::KIND_FIRST;
						res_q.fault <= mvdi_pkg::FAULT_RANGE;
						state_q <= ST_OUT;
					end else begin
						res_q.vertex_index <= 13'(item_q.pos_index) - 13'd1;
						res_q.fault <= mvdi_pkg::FAULT_NONE;
						if (!seen_rd) begin
							res_q.corner_kind <= mvdi_pkg::KIND_FIRST;
							state_q <= ST_FIRST;
						end else begin
							state_q <= ST_DUPRD;
						end
					end
				end
				ST_FIRST: begin
					state_q <= ST_OUT;
				end
				ST_DUPRD: begin
					if (slot_q == '0 && fv_rd == vtx) begin
						res_q.corner_kind <= mvdi_pkg::KIND_SAME;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DUPCMP;
					end
				end
				ST_DUPCMP: begin
					if (slot_q < dcount_q && dv_rd == vtx) begin
						res_q.corner_kind <= mvdi_pkg::KIND_DUP_OLD;
						res_q.vertex_index <= pcount_q + 13'(slot_q) - 13'd1;
						state_q <= ST_OUT;
					end else if (slot_q < dcount_q) begin
						slot_q <= slot_q + 1'b1;
						state_q <= ST_DUPRD;
					end else begin
						res_q.corner_kind <= mvdi_pkg::KIND_DUP_NEW;
						if (dcount_q < DCW'(MAX_DUPLICATES)) begin
							dcount_q <= dcount_q + 1'b1;
							res_q.vertex_index <= pcount_q + 13'(slot_q) - 13'd1;
						end else begin
							res_q.vertex_index <= '0;
							res_q.fault <= mvdi_pkg::FAULT_FULL;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						if (item_q.mesh_end) begin
							dcount_q <= '0;
							clr_q <= '0;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
